FILE: hdl/icf_pkg.sv
// Shared types, codes and constants for the integer constant-fold ALU.
`default_nettype none
package icf_pkg;
    localparam int unsigned DataW = 64;
    localparam int unsigned CntW = 7;

    typedef enum logic [2:0] {
        K_ADD = 3'd0, K_SUB = 3'd1, K_MUL = 3'd2, K_DIV = 3'd3, K_NEG = 3'd4, K_POW = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ST_FOLDED = 2'd0, ST_UNDEF = 2'd1, ST_NOFOLD = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]        kind;
        logic signed [63:0] left_operand;
        logic signed [63:0] right_operand;
    } t_in_word;

    typedef struct packed {
        logic signed [63:0] result_value;
        logic [1:0]         status;
    } t_out_word;

    typedef enum logic [2:0] {
        C_NONE, C_LOAD, C_DIV_STEP, C_POW_MUL, C_POW_SQR, C_MUL_ONE, C_FINISH
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op op;
    } t_cmd;

    typedef struct packed {
        logic     div_op;
        logic     pow_op;
        logic     mul_op;
        logic     direct;
        logic     exp_zero;
        logic     exp_odd;
        logic     cnt_last;
        logic     mul_done;
    } t_stat;
endpackage
`default_nettype wire

FILE: hdl/icf_datapath.sv
// Datapath: operand registers, restoring divider, 32-bit-partial multiplier and result.
`default_nettype none
module icf_datapath (
    input  wire logic          i_clk,
    input  wire icf_pkg::t_in_word i_word,
    input  wire icf_pkg::t_cmd i_cmd,
    output icf_pkg::t_stat     o_stat,
    output icf_pkg::t_out_word o_word
);
    logic [2:0]  r_kind;
    logic [63:0] r_b, r_acc, r_base, r_exp, r_rem, r_quo;
    logic        r_neg_q;
    logic [icf_pkg::CntW-1:0] r_cnt;
    logic [1:0]  r_phase;
    logic [63:0] r_m_x, r_m_y, r_m_sum;
    logic        r_m_sel;
    logic [63:0] r_val;
    logic [1:0]  r_st;
    logic        r_direct;

    logic [63:0] ua, ub, n_dir_val;
    logic [1:0]  n_dir_st;
    logic        n_dir;
    logic [64:0] rem_sh, rem_sub;
    logic [63:0] pp;
    logic [31:0] pa, pb;

    always_comb begin
        ua = i_word.left_operand[63] ? 64'(-i_word.left_operand) : i_word.left_operand;
        ub = i_word.right_operand[63] ? 64'(-i_word.right_operand) : i_word.right_operand;
        n_dir_val = '0;
        n_dir_st = icf_pkg::ST_FOLDED;
        n_dir = 1'b1;
        unique case (i_word.kind) inside
            icf_pkg::K_ADD: n_dir_val = i_word.left_operand + i_word.right_operand;
            icf_pkg::K_SUB: n_dir_val = i_word.left_operand - i_word.right_operand;
            icf_pkg::K_NEG: n_dir_val = 64'(-i_word.left_operand);
            icf_pkg::K_MUL: n_dir = 1'b0;
            icf_pkg::K_DIV: begin
                if (i_word.right_operand == '0) n_dir_st = icf_pkg::ST_UNDEF;
                else n_dir = 1'b0;
            end
            icf_pkg::K_POW: begin
                if (i_word.left_operand == '0)
                    n_dir_val = (i_word.right_operand == '0) ? 64'd1 : 64'd0;
                else if (i_word.left_operand == 64'd1) n_dir_val = 64'd1;
                else if (i_word.left_operand == '1)
                    n_dir_val = i_word.right_operand[0] ? '1 : 64'd1;
                else if (i_word.right_operand[63]) n_dir_st = icf_pkg::ST_NOFOLD;
                else n_dir = 1'b0;
            end
            default: n_dir_st = icf_pkg::ST_NOFOLD;
        endcase
    end

    assign rem_sh  = {r_rem, r_quo[63]};
    assign rem_sub = rem_sh - {1'b0, r_b};
    // Multiplier works on 32-bit halves: lo*lo, lo*hi, hi*lo over three phases.
    always_comb begin
        unique case (r_phase)
            2'd0: begin pa = r_m_x[31:0]; pb = r_m_y[31:0]; end
            2'd1: begin pa = r_m_x[31:0]; pb = r_m_y[63:32]; end
            default: begin pa = r_m_x[63:32]; pb = r_m_y[31:0]; end
        endcase
        pp = pa * pb;
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            icf_pkg::C_LOAD: begin
                r_kind <= i_word.kind;
                r_val <= n_dir_val;
                r_st <= n_dir_st;
                r_direct <= n_dir;
                r_quo <= ua;
                r_b <= ub;
                r_rem <= '0;
                r_neg_q <= i_word.left_operand[63] ^ i_word.right_operand[63];
                r_cnt <= '0;
                r_acc <= 64'd1;
                r_base <= i_word.left_operand;
                r_exp <= i_word.right_operand;
                r_m_x <= i_word.left_operand;
                r_m_y <= i_word.right_operand;
                r_m_sum <= '0;
                r_phase <= '0;
            end
            icf_pkg::C_DIV_STEP: begin
                if (!rem_sub[64]) begin
                    r_rem <= rem_sub[63:0];
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[63:0];
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
            end
            icf_pkg::C_POW_MUL, icf_pkg::C_POW_SQR: begin
                if (r_phase == 2'd0) begin
                    r_m_x <= (i_cmd.op == icf_pkg::C_POW_MUL) ? r_acc : r_base;
                    r_m_y <= r_base;
                    r_m_sel <= (i_cmd.op == icf_pkg::C_POW_MUL);
                    r_m_sum <= '0;
                    r_phase <= '0;
                end else begin
                    r_phase <= '0;
                end
            end
            icf_pkg::C_MUL_ONE: begin
                unique case (r_phase)
                    2'd0: begin r_m_sum <= pp; r_phase <= 2'd1; end
                    2'd1: begin
                        r_m_sum <= r_m_sum + {pp[31:0], 32'd0};
                        r_phase <= 2'd2;
                    end
                    2'd2: begin
                        r_m_sum <= r_m_sum + {pp[31:0], 32'd0};
                        r_phase <= 2'd3;
                    end
                    default: ;
                endcase
            end
            icf_pkg::C_FINISH: begin
                if (r_kind == icf_pkg::K_MUL) begin
                    r_val <= r_m_sum;
                end else if (r_kind == icf_pkg::K_DIV) begin
                    if (r_rem != '0) begin
                        r_st <= icf_pkg::ST_NOFOLD;
                        r_val <= '0;
                    end else r_val <= r_neg_q ? 64'(-r_quo) : r_quo;
                end else if (r_m_sel) begin
                    r_acc <= r_m_sum;
                    r_phase <= '0;
                end else begin
                    r_base <= r_m_sum;
                    r_exp <= {1'b0, r_exp[63:1]};
                    r_phase <= '0;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_stat.div_op = (r_kind == icf_pkg::K_DIV);
        o_stat.pow_op = (r_kind == icf_pkg::K_POW);
        o_stat.mul_op = (r_kind == icf_pkg::K_MUL);
        o_stat.direct = r_direct;
        o_stat.exp_zero = (r_exp == '0);
        o_stat.exp_odd = r_exp[0];
        o_stat.cnt_last = (r_cnt == icf_pkg::CntW'(63));
        o_stat.mul_done = (r_phase == 2'd3);
        o_word.result_value = (r_kind == icf_pkg::K_POW && !r_direct) ? r_acc : r_val;
        o_word.status = r_st;
    end
endmodule
`default_nettype wire

FILE: hdl/icf_ctrl.sv
// Controller: sequences load, divide, multiply and power rounds, and holds the output word.
`default_nettype none
module icf_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          i_out_stall,
    input  wire icf_pkg::t_stat i_stat,
    output icf_pkg::t_cmd      o_cmd,
    output logic               o_stall,
    output logic               o_valid
);
    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_DIV, S_DIV_FIN, S_MUL, S_MUL_FIN, S_POW_CHK,
        S_PM_SET, S_PM_RUN, S_PM_FIN, S_PS_SET, S_PS_RUN, S_PS_FIN, S_OUT
    } t_state;
    t_state r_state;
    logic   r_valid;

    always_comb begin
        o_cmd.op = icf_pkg::C_NONE;
        unique case (r_state)
            S_IDLE:    if (i_valid) o_cmd.op = icf_pkg::C_LOAD;
            S_DIV:     o_cmd.op = icf_pkg::C_DIV_STEP;
            S_DIV_FIN, S_PM_FIN, S_PS_FIN: o_cmd.op = icf_pkg::C_FINISH;
            S_MUL:     o_cmd.op = i_stat.mul_done ? icf_pkg::C_FINISH : icf_pkg::C_MUL_ONE;
            S_PM_SET:  o_cmd.op = icf_pkg::C_POW_MUL;
            S_PS_SET:  o_cmd.op = icf_pkg::C_POW_SQR;
            S_PM_RUN, S_PS_RUN: o_cmd.op = icf_pkg::C_MUL_ONE;
            default:   o_cmd.op = icf_pkg::C_NONE;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE:   if (i_valid) r_state <= S_DECODE;
                S_DECODE: begin
                    if (i_stat.direct) r_state <= S_OUT;
                    else if (i_stat.div_op) r_state <= S_DIV;
                    else if (i_stat.mul_op) r_state <= S_MUL;
                    else if (i_stat.pow_op) r_state <= S_POW_CHK;
                    else r_state <= S_OUT;
                end
                S_DIV:    if (i_stat.cnt_last) r_state <= S_DIV_FIN;
                S_DIV_FIN: r_state <= S_OUT;
                S_MUL:    if (i_stat.mul_done) r_state <= S_OUT;
                S_POW_CHK: begin
                    if (i_stat.exp_zero) r_state <= S_OUT;
                    else if (i_stat.exp_odd) r_state <= S_PM_SET;
                    else r_state <= S_PS_SET;
                end
                S_PM_SET: r_state <= S_PM_RUN;
                S_PM_RUN: if (i_stat.mul_done) r_state <= S_PM_FIN;
                S_PM_FIN: r_state <= S_PS_SET;
                S_PS_SET: r_state <= S_PS_RUN;
                S_PS_RUN: if (i_stat.mul_done) r_state <= S_PS_FIN;
                S_PS_FIN: r_state <= S_POW_CHK;
                S_OUT: begin
                    if (!r_valid) r_valid <= 1'b1;
                    else if (!i_out_stall) begin
                        r_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: hdl/integer_constant_fold_alu_unit.sv
// Top level of the integer constant-fold ALU: controller plus datapath.
// One word at a time: the input stalls from acceptance until the result word is taken, and
// the next word can be taken in the following cycle. Add, subtract, negate and immediate
// cases go straight to the output; multiply forms three 32x32 partial products; divide runs
// one restoring step a cycle over 64 steps; power runs one round per exponent bit, a square
// each round plus a multiply when the bit is set, so up to 63 rounds, all on the shared
// 32-bit multiplier.
`default_nettype none
module integer_constant_fold_alu_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire icf_pkg::t_in_word  i_word,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output icf_pkg::t_out_word      o_word
);
    icf_pkg::t_cmd  cmd;
    icf_pkg::t_stat stat;

    icf_datapath u_dp (
        .i_clk(i_clk), .i_word(i_word), .i_cmd(cmd), .o_stat(stat), .o_word(o_word)
    );
    icf_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_out_stall(i_stall),
        .i_stat(stat), .o_cmd(cmd), .o_stall(o_stall), .o_valid(o_valid)
    );

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("output valid while input open");
    a_zero_unfolded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word.status != icf_pkg::ST_FOLDED |-> o_word.result_value == '0)
        else $error("unfolded result not zero");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_word)) else $error("output dropped");
endmodule
`default_nettype wire

FILE: verif/integer_constant_fold_alu_unit_tb.sv
// Self-checking testbench for the integer constant-fold ALU: directed and random words.
`timescale 1ns / 100ps
`default_nettype none
module integer_constant_fold_alu_unit_tb;
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    icf_pkg::t_in_word i_word = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    icf_pkg::t_out_word o_word;

    icf_pkg::t_out_word fold_queue[$];
    int unsigned fault_count = 0;
    bit hold_off = 1'b0;
    bit rx_done = 1'b0;

    localparam logic [63:0] MinVal = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MaxVal = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] AllOnes = '1;

    integer_constant_fold_alu_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_word(i_word), .o_valid(o_valid), .i_stall(i_stall), .o_word(o_word)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] pow_by_squaring(logic [63:0] base, logic [63:0] expo);
        logic [63:0] acc;
        acc = 64'd1;
        while (expo != 0) begin
            if (expo[0]) acc = acc * base;
            base = base * base;
            expo = expo >> 1;
        end
        return acc;
    endfunction

    function automatic icf_pkg::t_out_word fold_result(icf_pkg::t_in_word w);
        icf_pkg::t_out_word r;
        logic [63:0] a, b, ua, ub, q;
        a = w.left_operand;
        b = w.right_operand;
        r.result_value = '0;
        r.status = icf_pkg::ST_FOLDED;
        case (w.kind)
            icf_pkg::K_ADD: r.result_value = a + b;
            icf_pkg::K_SUB: r.result_value = a - b;
            icf_pkg::K_MUL: r.result_value = a * b;
            icf_pkg::K_DIV: begin
                if (b == 0) begin
                    r.status = icf_pkg::ST_UNDEF;
                end else begin
                    ua = a[63] ? -a : a;
                    ub = b[63] ? -b : b;
                    q = ua / ub;
                    if (ua % ub != 0) r.status = icf_pkg::ST_NOFOLD;
                    else r.result_value = (a[63] != b[63]) ? -q : q;
                end
            end
            icf_pkg::K_NEG: r.result_value = -a;
            icf_pkg::K_POW: begin
                if (a == 0) r.result_value = (b == 0) ? 64'd1 : 64'd0;
                else if (a == 1) r.result_value = 64'd1;
                else if (a == AllOnes) r.result_value = b[0] ? AllOnes : 64'd1;
                else if (b[63]) r.status = icf_pkg::ST_NOFOLD;
                else r.result_value = pow_by_squaring(a, b);
            end
            default: r.status = icf_pkg::ST_NOFOLD;
        endcase
        if (r.status != icf_pkg::ST_FOLDED) r.result_value = '0;
        return r;
    endfunction

    function automatic int unsigned gap_len();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [63:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return {$urandom, $urandom};
            1: return 64'($signed($urandom_range(0, 20)) - 10);
            2: return MinVal;
            3: return MaxVal;
            4: return 64'($urandom_range(0, 1000));
            5: return -64'($urandom_range(0, 1000));
            6: return {{32{1'b0}}, $urandom};
            default: return {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
    endfunction

    task automatic send_word(logic [2:0] kind, logic [63:0] a, logic [63:0] b);
        icf_pkg::t_in_word w;
        int unsigned gap;
        w.kind = kind;
        w.left_operand = a;
        w.right_operand = b;
        i_valid <= 1'b1;
        i_word <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        fold_queue = {fold_queue, fold_result(w)};
        gap = gap_len();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic test_arith_extremes();
        logic [63:0] edge_vals[6];
        edge_vals = '{64'd0, 64'd1, AllOnes, MinVal, MaxVal, 64'h5555_aaaa_f0f0_0f0f};
        for (int k = icf_pkg::K_ADD; k <= icf_pkg::K_NEG; k++)
            for (int j = 0; j < 3; j++)
                send_word(k[2:0], edge_vals[j + 2], edge_vals[5 - j]);
        send_word(3'd6, MaxVal, MinVal);
        send_word(3'd7, AllOnes, AllOnes);
    endtask

    task automatic test_div_cases();
        send_word(icf_pkg::K_DIV, 64'd42, 64'd0);
        send_word(icf_pkg::K_DIV, 64'd7, 64'd2);
        send_word(icf_pkg::K_DIV, -64'd9, 64'd3);
        send_word(icf_pkg::K_DIV, MinVal, AllOnes);
        send_word(icf_pkg::K_DIV, -64'd7, 64'd2);
    endtask

    task automatic test_pow_cases();
        send_word(icf_pkg::K_POW, 64'd0, 64'd0);
        send_word(icf_pkg::K_POW, 64'd0, AllOnes);
        send_word(icf_pkg::K_POW, 64'd1, MinVal);
        send_word(icf_pkg::K_POW, AllOnes, -64'd3);
        send_word(icf_pkg::K_POW, AllOnes, MinVal);
        send_word(icf_pkg::K_POW, 64'd3, AllOnes);
        send_word(icf_pkg::K_POW, 64'd3, MaxVal);
        send_word(icf_pkg::K_POW, 64'd2, 64'd64);
    endtask

    task automatic test_random_words();
        logic [2:0] kind;
        logic [63:0] b;
        for (int n = 0; n < 700; n++) begin
            kind = ($urandom_range(0, 24) == 0) ? 3'($urandom_range(6, 7))
                                                : 3'($urandom_range(0, 5));
            b = rand_operand();
            if (kind == icf_pkg::K_POW && $urandom_range(0, 3) != 0)
                b = 64'($urandom_range(0, 40));
            send_word(kind, rand_operand(), b);
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int n = 0; n < 20; n++)
            send_word(3'($urandom_range(0, 5)), rand_operand(), 64'($urandom_range(0, 9)));
    endtask

    // result receiver with random stalls and one long hold-off
    initial begin
        int unsigned stall_cnt;
        stall_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                if (fold_queue.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, o_word);
                    fault_count++;
                end else begin
                    icf_pkg::t_out_word exp_w;
                    exp_w = fold_queue.pop_front();
                    if (o_word.result_value !== exp_w.result_value)
                        $display("%0t: value exp %h got %h", $time,
                                 exp_w.result_value, o_word.result_value);
                    if (o_word.status !== exp_w.status)
                        $display("%0t: status exp %0d got %0d", $time,
                                 exp_w.status, o_word.status);
                    if (o_word !== exp_w) fault_count++;
                end
            end
            if (hold_off && !rx_done) begin
                rx_done = 1'b1;
                stall_cnt = 300;
            end
            if (stall_cnt > 0) begin
                stall_cnt--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 3) == 0) ? 1'b1 : 1'b0;
                if ($urandom_range(0, 49) == 0) stall_cnt = $urandom_range(10, 40);
            end
        end
    end

    initial begin
        int unsigned wait_cnt;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_arith_extremes();
        test_div_cases();
        test_pow_cases();
        test_backpressure();
        test_random_words();
        i_valid <= 1'b0;
        wait_cnt = 0;
        while (fold_queue.size() != 0 && wait_cnt < 200000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (200) @(posedge i_clk);
        if (fault_count == 0 && fold_queue.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
